>>> hw/rtl/plist_pkg.sv
`default_nettype none

package plist_pkg;

  // Command codes carried in the cmd field.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Status codes returned in the result_status field.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_POS = 2'd2;

  localparam int VAL_W   = 32;
  localparam int POS_W   = 8;
  localparam int CNT_OUT = 8;

  // Sign class of one element; exactly one bit is set for a real element.
  typedef struct packed {
    logic pos;
    logic neg;
    logic zero;
  } val_class_t;

  // Shift controls broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

  function automatic val_class_t classify(input logic [VAL_W-1:0] v);
    val_class_t c;
    c.zero = (v == '0);
    c.neg  = v[VAL_W-1];
    c.pos  = (v != '0) && !v[VAL_W-1];
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/plist_cell.sv
`default_nettype none

module plist_cell #(
  parameter int IDX = 0,
  parameter int IW  = 7
) (
  input  wire                        clk,
  input  wire plist_pkg::cell_ctl_t  ctl,
  input  wire  [IW-1:0]              slot,
  input  wire  [plist_pkg::VAL_W-1:0] left_val,
  input  wire  [plist_pkg::VAL_W-1:0] right_val,
  input  wire  [plist_pkg::VAL_W-1:0] ins_val,
  output logic [plist_pkg::VAL_W-1:0] value,
  output plist_pkg::val_class_t      removed
);
  import plist_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic hit;
  logic above;

  assign hit   = (slot == MY_IDX);
  assign above = (MY_IDX > slot);

  // The cell that is deleted reports the sign class of what it held.
  always_comb begin
    removed = '0;
    if (ctl.del && hit) begin
      removed = classify(value);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (hit) begin
        value <= ins_val;
      end else if (above) begin
        value <= left_val;
      end
    end else if (ctl.del) begin
      if (hit || above) begin
        value <= right_val;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/positional_insert_delete_list_top.sv
// A result word is registered from its input word when that word is accepted.
// One word per cycle while results are taken or none is held; every cell of the chain
// shifts in the same cycle, so an insert or a delete never takes longer than a query.
// Reset (rst, synchronous, active high) empties the list and clears all tallies.
// The element cells are not cleared; a cell is only read once it has been written.
`default_nettype none

module positional_insert_delete_list_top #(
  parameter int CAPACITY = 128
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // s_tdata, low bit up: cmd[1:0], position[9:2], item_value[41:10], zero pad[47:42].
  input  wire  [47:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // m_tdata, low bit up: result_status[1:0], elem_count[9:2], positive_count[17:10],
  // negative_count[25:18], zero_count[33:26], zero pad[39:34].
  output logic [39:0] m_tdata
);
  import plist_pkg::*;

  // Count registers must hold CAPACITY itself; slot indexes need only CAPACITY-1.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Width in which position and counts are compared without losing bits.
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Unpack the incoming word.
  logic [1:0]       cmd;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] item_value;

  assign cmd        = s_tdata[1:0];
  assign position   = s_tdata[9:2];
  assign item_value = s_tdata[41:10];

  // List state.
  logic [CW-1:0] held_count;
  logic [CW-1:0] pos_tally;
  logic [CW-1:0] neg_tally;
  logic [CW-1:0] zero_tally;

  logic [CW-1:0] held_count_next;
  logic [CW-1:0] pos_tally_next;
  logic [CW-1:0] neg_tally_next;
  logic [CW-1:0] zero_tally_next;
  logic [1:0]    status_next;

  // Result register.
  logic [1:0]         status;
  logic [CNT_OUT-1:0] elem_count;
  logic [CNT_OUT-1:0] positive_count;
  logic [CNT_OUT-1:0] negative_count;
  logic [CNT_OUT-1:0] zero_count;

  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Decode the command against the current fill level.
  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [PW-1:0] ins_pos;
  logic          full;
  logic          del_bad;
  logic          do_ins;
  logic          do_del;
  logic [IW-1:0] slot;
  cell_ctl_t     ctl;
  val_class_t    new_class;
  val_class_t    gone_class;

  always_comb begin
    pos_w   = PW'(position);
    cnt_w   = PW'(held_count);
    full    = (held_count == CAP_C);
    // Position zero behaves as position one for an insert.
    ins_pos = (pos_w == '0) ? PW'(1) : pos_w;
    del_bad = (held_count == '0) || (pos_w == '0) || (pos_w > cnt_w);
    do_ins  = accept && (cmd == CMD_INSERT) && !full;
    do_del  = accept && (cmd == CMD_DELETE) && !del_bad;
    // An insert past the end appends at the first free cell.
    if (cmd == CMD_INSERT) begin
      slot = (ins_pos > cnt_w) ? IW'(cnt_w) : IW'(ins_pos - PW'(1));
    end else begin
      slot = IW'(pos_w - PW'(1));
    end
    ctl.ins = do_ins;
    ctl.del = do_del;
  end

  // The chain of cells: cell i holds the element at position i+1.
  logic [VAL_W-1:0] cell_val [CAPACITY];
  val_class_t       cell_rem [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = item_value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = item_value;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    plist_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .slot      (slot),
      .left_val  (left_v),
      .right_val (right_v),
      .ins_val   (item_value),
      .value     (cell_val[i]),
      .removed   (cell_rem[i])
    );
  end

  // Only the deleted cell reports a class, so an OR across the row picks it out.
  always_comb begin
    gone_class = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      gone_class = gone_class | cell_rem[i];
    end
  end

  assign new_class = classify(item_value);

  always_comb begin
    held_count_next = held_count;
    pos_tally_next  = pos_tally;
    neg_tally_next  = neg_tally;
    zero_tally_next = zero_tally;
    status_next     = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          held_count_next = held_count + CW'(1);
          pos_tally_next  = pos_tally + CW'(new_class.pos);
          neg_tally_next  = neg_tally + CW'(new_class.neg);
          zero_tally_next = zero_tally + CW'(new_class.zero);
        end
      end
      CMD_DELETE: begin
        if (del_bad) begin
          status_next = ST_BAD_POS;
        end else begin
          held_count_next = held_count - CW'(1);
          pos_tally_next  = pos_tally - CW'(gone_class.pos);
          neg_tally_next  = neg_tally - CW'(gone_class.neg);
          zero_tally_next = zero_tally - CW'(gone_class.zero);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      pos_tally  <= '0;
      neg_tally  <= '0;
      zero_tally <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        held_count <= held_count_next;
        pos_tally  <= pos_tally_next;
        neg_tally  <= neg_tally_next;
        zero_tally <= zero_tally_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is only looked at under m_tvalid.
  always_ff @(posedge clk) begin
    if (accept) begin
      status         <= status_next;
      elem_count     <= CNT_OUT'(held_count_next);
      positive_count <= CNT_OUT'(pos_tally_next);
      negative_count <= CNT_OUT'(neg_tally_next);
      zero_count     <= CNT_OUT'(zero_tally_next);
    end
  end

  assign m_tdata = {6'd0, zero_count, negative_count, positive_count, elem_count, status};

  // Every held element falls into exactly one sign class.
  a_tally_sum : assert property (@(posedge clk) disable iff (rst)
    (CW'(pos_tally + neg_tally + zero_tally) == held_count))
    else $error("tallies do not add up to the element count");

  a_never_over : assert property (@(posedge clk) disable iff (rst)
    (held_count <= CAP_C))
    else $error("element count beyond capacity");

  a_ins_grows : assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_INSERT) && !full) |=> (held_count == $past(held_count) + CW'(1)))
    else $error("accepted insert did not grow the list");

  a_refused_holds : assert property (@(posedge clk) disable iff (rst)
    (accept && (status_next != ST_OK)) |=> (held_count == $past(held_count)))
    else $error("refused command changed the list");

  a_one_removed : assert property (@(posedge clk) disable iff (rst)
    do_del |-> $onehot(gone_class))
    else $error("delete did not pick exactly one sign class");

endmodule

`default_nettype wire

>>> dv/plist_tally_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the positional list, keeps its own copy of
// the list and predicts the status and tallies for every accepted word.
module plist_tally_checker #(
  parameter int CAPACITY = 128
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [47:0] s_tdata,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [39:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  import plist_pkg::*;

  typedef struct {
    logic [1:0] status;
    logic [7:0] elems;
    logic [7:0] positives;
    logic [7:0] negatives;
    logic [7:0] zeros;
  } tally_word_t;

  logic [VAL_W-1:0] shadow_cells [CAPACITY];
  int unsigned      shadow_len;
  int unsigned      shadow_pos;
  int unsigned      shadow_neg;
  int unsigned      shadow_zero;

  tally_word_t expected_tallies [$];
  tally_word_t want;
  int          mismatches = 0;

  // Moves one element into or out of the sign tallies.
  function automatic void count_sign(input logic [VAL_W-1:0] v, input bit add);
    int delta;
    delta = add ? 1 : -1;
    if (v == '0)
      shadow_zero = shadow_zero + delta;
    else if (v[VAL_W-1])
      shadow_neg = shadow_neg + delta;
    else
      shadow_pos = shadow_pos + delta;
  endfunction

  function automatic tally_word_t predict_list_word(input logic [1:0] cmd,
                                                    input logic [POS_W-1:0] position,
                                                    input logic [VAL_W-1:0] value);
    tally_word_t w;
    int unsigned p;
    int unsigned slot;
    w.status = ST_OK;
    p = position;
    if (cmd == CMD_INSERT) begin
      if (shadow_len >= CAPACITY) begin
        w.status = ST_FULL;
      end else begin
        if (p == 0) p = 1;
        slot = (p > shadow_len) ? shadow_len : p - 1;
        for (int unsigned i = shadow_len; i > slot; i--)
          shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[slot] = value;
        shadow_len++;
        count_sign(value, 1'b1);
      end
    end else if (cmd == CMD_DELETE) begin
      if (shadow_len == 0 || p == 0 || p > shadow_len) begin
        w.status = ST_BAD_POS;
      end else begin
        count_sign(shadow_cells[p-1], 1'b0);
        for (int unsigned i = p - 1; i + 1 < shadow_len; i++)
          shadow_cells[i] = shadow_cells[i+1];
        shadow_len--;
      end
    end
    w.elems     = shadow_len[7:0];
    w.positives = shadow_pos[7:0];
    w.negatives = shadow_neg[7:0];
    w.zeros     = shadow_zero[7:0];
    return w;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_len  = 0;
      shadow_pos  = 0;
      shadow_neg  = 0;
      shadow_zero = 0;
      expected_tallies.delete();
    end else begin
      // The result leaving now always belongs to an earlier input word.
      if (m_tvalid && m_tready) begin
        if (expected_tallies.size() == 0) begin
          $error("result word 0x%h arrived with no input word waiting", m_tdata);
          mismatches++;
        end else begin
          want = expected_tallies.pop_front();
          check_field("result_status", want.status, m_tdata[1:0]);
          check_field("elem_count", want.elems, m_tdata[9:2]);
          check_field("positive_count", want.positives, m_tdata[17:10]);
          check_field("negative_count", want.negatives, m_tdata[25:18]);
          check_field("zero_count", want.zeros, m_tdata[33:26]);
          check_field("zero pad", 0, m_tdata[39:34]);
        end
      end
      if (s_tvalid && s_tready)
        expected_tallies.push_back(predict_list_word(s_tdata[1:0], s_tdata[9:2],
                                                     s_tdata[41:10]));
    end
    fail_count <= mismatches;
    pending    <= expected_tallies.size();
  end

endmodule

>>> dv/positional_insert_delete_list_top_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the positional list. The checker beside the block
// does all prediction and comparison; this module only makes words and waits.
module positional_insert_delete_list_top_test;
  import plist_pkg::*;

  localparam int         CAPACITY   = 128;
  // The fourth cmd code has no meaning of its own; the block must treat it as a query.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         RANDOM_WORDS = 1600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata, low bit up: cmd[1:0], position[9:2], item_value[41:10], zero pad[47:42].
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata, low bit up: result_status[1:0], elem_count[9:2], positive_count[17:10],
  // negative_count[25:18], zero_count[33:26], zero pad[39:34].
  logic [39:0] m_tdata;

  int fail_count;
  int pending;

  // Percentages of cycles in which the sender holds back a word and the
  // receiver refuses one. They change between the phases of the run.
  int snd_idle_pct  = 21;
  int rcv_stall_pct = 88;

  // Rough length of the list as the stimulus sees it, used only to aim
  // positions at the interesting range; the checker keeps the real copy.
  int list_len = 0;

  positional_insert_delete_list_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  plist_tally_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver decides afresh on every falling edge whether it takes a word.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Offers one word, with random idle cycles in front of it, and returns once
  // the block has accepted it. The valid stays high into the next call, so a
  // back-to-back word is never lowered and raised within one step.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] position,
                           input logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, value, position, cmd};
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_INSERT && list_len < CAPACITY)
      list_len++;
    else if (cmd == CMD_DELETE && position >= 1 && position <= list_len)
      list_len--;
  endtask

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [1:0]  cmd;
    logic [7:0]  position;
    logic [31:0] value;
    int          ins_pct;
    int          pick;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words on a short list: the empty list, position zero, appends
    // past the end, an insert at the last position, refused deletes, the
    // extremes of the value, and the unused command code.
    send_word(CMD_QUERY,  8'd0,   32'h0000_0000);
    send_word(CMD_DELETE, 8'd1,   32'hFFFF_FFFF);  // empty list
    send_word(CMD_INSERT, 8'd0,   32'h0000_0000);  // position zero acts as one
    send_word(CMD_INSERT, 8'd255, 32'h7FFF_FFFF);  // far past the end appends
    send_word(CMD_INSERT, 8'd2,   32'h8000_0000);  // lands before the last element
    send_word(CMD_INSERT, 8'd1,   32'hFFFF_FFFF);
    send_word(CMD_INSERT, 8'd3,   32'h0000_0001);
    send_word(CMD_UNUSED, 8'd255, 32'hFFFF_FFFF);
    send_word(CMD_DELETE, 8'd0,   32'h0000_0000);  // position zero is refused
    send_word(CMD_DELETE, 8'd255, 32'h0000_0000);
    send_word(CMD_DELETE, 8'd6,   32'h0000_0000);  // one past the count
    send_word(CMD_DELETE, 8'd5,   32'h0000_0000);  // the last element
    send_word(CMD_DELETE, 8'd1,   32'h0000_0000);
    send_word(CMD_QUERY,  8'd128, 32'h5555_5555);
    send_word(CMD_INSERT, 8'd128, 32'h5555_5555);
    send_word(CMD_INSERT, 8'd1,   32'hAAAA_AAAA);
    send_word(CMD_DELETE, 8'd4,   32'h0000_0000);
    while (list_len > 0)
      send_word(CMD_DELETE, 8'd1, 32'h0000_0000);
    send_word(CMD_DELETE, 8'd1, 32'h0000_0000);    // empty again

    // Random words in bursts of 200 that fill the list up to full, wander,
    // drain it to empty and wander again, so full and empty both recur.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        snd_idle_pct  = 88;
        rcv_stall_pct = 21;
      end else if (n == 2 * RANDOM_WORDS / 3) begin
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
      end

      case ((n / 200) % 4)
        0:       ins_pct = 85;
        2:       ins_pct = 15;
        default: ins_pct = 50;
      endcase

      pick = $urandom_range(99);
      if (pick < 4)
        cmd = CMD_QUERY;
      else if (pick < 6)
        cmd = CMD_UNUSED;
      else if (pick < 6 + ins_pct * 94 / 100)
        cmd = CMD_INSERT;
      else
        cmd = CMD_DELETE;

      // Mostly positions inside the list or one past it, with some on the
      // count itself, some at zero and some anywhere in the field.
      pick = $urandom_range(99);
      if (pick < 10)
        position = 8'($urandom_range(255, 0));
      else if (pick < 15)
        position = 8'(list_len);
      else if (pick < 20)
        position = 8'd0;
      else if (cmd == CMD_DELETE && list_len > 0)
        position = 8'($urandom_range(list_len, 1));
      else
        position = 8'($urandom_range(list_len + 1, 0));

      case ($urandom_range(3))
        0: value = 32'h0000_0000;
        1: value = $urandom_range(20) - 10;
        2: value = $urandom;
        default: begin
          case ($urandom_range(3))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'hFFFF_FFFF;
            default: value = 32'h0000_0001;
          endcase
        end
      endcase

      send_word(cmd, position, value);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;

    // Let every outstanding result drain, then a few more cycles so that a
    // stray extra word from the block would still be caught.
    while (pending != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
